>>> rtl/espd_pkg.sv
// ----------------------------------------------------------------------------
// espd_pkg
// Shared types and constants for the encoder speed PD regulator.
// ----------------------------------------------------------------------------
package espd_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned GAIN_W  = 8;
    localparam int unsigned DRIVE_W = 11;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Upper clamp of the drive value
    localparam logic [SPEED_W-1:0] DRIVE_MAX = 16'd1024;

    // Arithmetic right shifts of current and previous error
    localparam int unsigned P_SHIFT = 3;
    localparam int unsigned D_SHIFT = 4;

    typedef enum logic [1:0] {
        KIND_PULSE = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED = 2'd0,
        CFG_PROP_GAIN    = 2'd1,
        CFG_DIFF_GAIN    = 2'd2,
        CFG_AUTO_MODE    = 2'd3
    } t_cfg_idx;

    // Gains and set point handed to the PD law
    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  diff_gain;
    } t_pd_cfg;

endpackage

>>> rtl/espd_pd_law.sv
// ----------------------------------------------------------------------------
// espd_pd_law
// Combinational PD drive update in 16-bit wrapping arithmetic, clamped 0..1024.
// ----------------------------------------------------------------------------
module espd_pd_law (
    input  espd_pkg::t_pd_cfg                      i_cfg,
    input  logic [espd_pkg::SPEED_W-1:0]           i_speed,
    input  logic signed [espd_pkg::SPEED_W-1:0]    i_prev_error,
    input  logic [espd_pkg::DRIVE_W-1:0]           i_current_drive,
    output logic signed [espd_pkg::SPEED_W-1:0]    o_error,
    output logic [espd_pkg::DRIVE_W-1:0]           o_drive
);
    import espd_pkg::*;

    logic signed [SPEED_W-1:0]        err_shr;
    logic signed [SPEED_W-1:0]        prev_shr;
    logic signed [SPEED_W+GAIN_W:0]   p_term;
    logic signed [SPEED_W+GAIN_W:0]   d_term;
    logic [SPEED_W-1:0]               sum;

    assign o_error  = $signed(i_cfg.target_speed - i_speed);
    assign err_shr  = o_error >>> P_SHIFT;
    assign prev_shr = i_prev_error >>> D_SHIFT;

    assign p_term = $signed({1'b0, i_cfg.prop_gain}) * err_shr;
    assign d_term = $signed({1'b0, i_cfg.diff_gain}) * prev_shr;

    // only the low 16 bits matter: the sum wraps there
    assign sum = {{(SPEED_W-DRIVE_W){1'b0}}, i_current_drive}
               + p_term[SPEED_W-1:0] - d_term[SPEED_W-1:0];

    always_comb begin
        if (sum[SPEED_W-1]) begin
            o_drive = '0;
        end else if (sum > DRIVE_MAX) begin
            o_drive = DRIVE_MAX[DRIVE_W-1:0];
        end else begin
            o_drive = sum[DRIVE_W-1:0];
        end
    end

endmodule

>>> rtl/encoder_speed_pd_regulator_top.sv
// ----------------------------------------------------------------------------
// encoder_speed_pd_regulator_top
// Encoder pulse counter with speed latch and PD drive regulation.
// ----------------------------------------------------------------------------
// Each input word is an encoder pulse, a timer tick or a position clear, and
// each produces exactly one status word. One word is taken per cycle when
// not stalled: the counters and the PD law (two 8x16 multiplies and a 16-bit
// add/clamp) all settle between the input handshake and the output register,
// so results are registered at acceptance. The output register frees itself
// in the cycle it is taken, so a new word can enter while the last status
// word is leaving. A pulse bumps the 32-bit pulse total, the 16-bit period
// count and moves the signed position by the direction level. A tick latches
// the period count as speed, clears the count and, in auto mode, computes a
// new drive value and reports it with drive_valid. Clear zeroes pulse total
// and position only. Configuration registers: 0 target_speed, 1 prop_gain,
// 2 diff_gain, 3 auto_mode; write only while no word is in flight.
// ----------------------------------------------------------------------------
module encoder_speed_pd_regulator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic                                i_dir_level,
    input  logic [espd_pkg::DRIVE_W-1:0]        i_current_drive,
    // status words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [espd_pkg::SPEED_W-1:0]        o_speed,
    output logic [1:0]                          o_direction,
    output logic [espd_pkg::COUNT_W-1:0]        o_pulse_total,
    output logic signed [espd_pkg::COUNT_W-1:0] o_position,
    output logic                                o_drive_valid,
    output logic [espd_pkg::DRIVE_W-1:0]        o_drive_value,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [espd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [espd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import espd_pkg::*;

    // configuration
    t_pd_cfg                    r_cfg;
    logic                       r_auto_mode;

    // regulator state
    logic [COUNT_W-1:0]         r_abs_count,    n_abs_count;
    logic [COUNT_W-1:0]         r_signed_count, n_signed_count;
    logic [SPEED_W-1:0]         r_period_count, n_period_count;
    logic [SPEED_W-1:0]         r_speed,        n_speed;
    t_dir                       r_last_dir,     n_last_dir;
    logic signed [SPEED_W-1:0]  r_prev_error,   n_prev_error;
    logic                       n_drive_valid;
    logic [DRIVE_W-1:0]         n_drive_value;

    // output register
    logic                       r_out_valid;
    logic [SPEED_W-1:0]         r_o_speed;
    t_dir                       r_o_dir;
    logic [COUNT_W-1:0]         r_o_total;
    logic [COUNT_W-1:0]         r_o_pos;
    logic                       r_o_dvalid;
    logic [DRIVE_W-1:0]         r_o_dvalue;

    logic                       in_accept;
    logic signed [SPEED_W-1:0]  pd_error;
    logic [DRIVE_W-1:0]         pd_drive;

    // ------------------------------------------------------------------
    // Handshakes: stall input only while a status word is held back
    // ------------------------------------------------------------------
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed <= '0;
            r_cfg.prop_gain    <= GAIN_W'(1);
            r_cfg.diff_gain    <= GAIN_W'(1);
            r_auto_mode        <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_SPEED: r_cfg.target_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_DIFF_GAIN:    r_cfg.diff_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_AUTO_MODE:    r_auto_mode        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // PD law; fed the freshly latched speed (the period count)
    // ------------------------------------------------------------------
    espd_pd_law u_pd_law (
        .i_cfg           (r_cfg),
        .i_speed         (r_period_count),
        .i_prev_error    (r_prev_error),
        .i_current_drive (i_current_drive),
        .o_error         (pd_error),
        .o_drive         (pd_drive)
    );

    // ------------------------------------------------------------------
    // Next-state decode per word kind
    // ------------------------------------------------------------------
    always_comb begin
        n_abs_count    = r_abs_count;
        n_signed_count = r_signed_count;
        n_period_count = r_period_count;
        n_speed        = r_speed;
        n_last_dir     = r_last_dir;
        n_prev_error   = r_prev_error;
        n_drive_valid  = 1'b0;
        n_drive_value  = '0;
        unique case (t_kind'(i_kind))
            KIND_PULSE: begin
                n_abs_count    = r_abs_count + COUNT_W'(1);
                n_period_count = r_period_count + SPEED_W'(1);
                if (i_dir_level) begin
                    n_last_dir     = DIR_FWD;
                    n_signed_count = r_signed_count + COUNT_W'(1);
                end else begin
                    n_last_dir     = DIR_BWD;
                    n_signed_count = r_signed_count - COUNT_W'(1);
                end
            end
            KIND_TICK: begin
                n_speed        = r_period_count;
                n_period_count = '0;
                if (r_auto_mode) begin
                    n_prev_error  = pd_error;
                    n_drive_valid = 1'b1;
                    n_drive_value = pd_drive;
                end
            end
            KIND_CLEAR: begin
                n_abs_count    = '0;
                n_signed_count = '0;
            end
            default: ;  // unused kind: status only
        endcase
    end

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_count    <= '0;
            r_signed_count <= '0;
            r_period_count <= '0;
            r_speed        <= '0;
            r_last_dir     <= DIR_STOP;
            r_prev_error   <= '0;
        end else if (in_accept) begin
            r_abs_count    <= n_abs_count;
            r_signed_count <= n_signed_count;
            r_period_count <= n_period_count;
            r_speed        <= n_speed;
            r_last_dir     <= n_last_dir;
            r_prev_error   <= n_prev_error;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_o_speed  <= n_speed;
            r_o_dir    <= (n_speed == '0) ? DIR_STOP : n_last_dir;
            r_o_total  <= n_abs_count;
            r_o_pos    <= n_signed_count;
            r_o_dvalid <= n_drive_valid;
            r_o_dvalue <= n_drive_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_speed       = r_o_speed;
    assign o_direction   = r_o_dir;
    assign o_pulse_total = r_o_total;
    assign o_position    = $signed(r_o_pos);
    assign o_drive_valid = r_o_dvalid;
    assign o_drive_value = r_o_dvalue;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stop_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_speed == '0) |-> o_direction == DIR_STOP)
        else $error("direction not stopped at zero speed");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_valid) |-> o_drive_value == '0)
        else $error("drive value without drive_valid");

    a_pulse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_kind == KIND_PULSE)
            |=> r_period_count == $past(r_period_count) + SPEED_W'(1))
        else $error("period count missed a pulse");

    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_kind == KIND_TICK)
            |=> (r_period_count == '0 && o_speed == $past(r_period_count)))
        else $error("tick did not latch speed");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the encoder speed PD regulator.
// ----------------------------------------------------------------------------
// Input words (pulse, tick, clear and the unused kind) go in through the
// valid/stall channel in bursts with random gaps. The receiver stalls the
// status channel on a pattern that switches mode at random points. Each
// accepted word runs through a local copy of the regulator: counters, speed
// latch, direction and the PD drive law. The status it should produce is
// queued, and every status word taken from the block is checked field by
// field against the oldest entry. Registers are only written once the block
// has drained. A short directed run comes first, then random phases with
// fresh gains, set point and mode each time, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import espd_pkg::*;

    // Kind code that the block must ignore apart from reporting status
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Second encoder channel level at a pulse
    localparam logic LEVEL_FWD = 1'b1;
    localparam logic LEVEL_BWD = 1'b0;

    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 135;
    localparam int SETTLE_CYCLES = 3;

    typedef struct {
        logic [SPEED_W-1:0]        speed;
        logic [1:0]                direction;
        logic [COUNT_W-1:0]        pulse_total;
        logic signed [COUNT_W-1:0] position;
        logic                      drive_valid;
        logic [DRIVE_W-1:0]        drive_value;
    } t_status;

    // ------------------------------------------------------------------------
    // Regulator model and status scoreboard
    // ------------------------------------------------------------------------
    class regulator_model;
        logic [SPEED_W-1:0]        target_speed;
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         diff_gain;
        logic                      auto_mode;
        logic [COUNT_W-1:0]        pulse_total;
        logic [COUNT_W-1:0]        position;
        logic [SPEED_W-1:0]        period_count;
        logic [SPEED_W-1:0]        speed;
        t_dir                      last_dir;
        logic signed [SPEED_W-1:0] prev_error;
        t_status                   pending_status[$];
        int                        errors;

        function new();
            target_speed = '0;
            prop_gain    = 8'd1;
            diff_gain    = 8'd1;
            auto_mode    = 1'b0;
            pulse_total  = '0;
            position     = '0;
            period_count = '0;
            speed        = '0;
            last_dir     = DIR_STOP;
            prev_error   = '0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TARGET_SPEED: target_speed = data[SPEED_W-1:0];
                CFG_PROP_GAIN:    prop_gain    = data[GAIN_W-1:0];
                CFG_DIFF_GAIN:    diff_gain    = data[GAIN_W-1:0];
                CFG_AUTO_MODE:    auto_mode    = data[0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted word and queue its status
        function void take_word(logic [1:0] kind, logic dir_level,
                                logic [DRIVE_W-1:0] drive);
            t_status                   s;
            logic signed [SPEED_W-1:0] err;
            logic signed [15:0]        sum16;
            int                        sum;
            s.drive_valid = 1'b0;
            s.drive_value = '0;
            case (kind)
                KIND_PULSE: begin
                    pulse_total  = pulse_total + COUNT_W'(1);
                    period_count = period_count + SPEED_W'(1);
                    if (dir_level) begin
                        last_dir = DIR_FWD;
                        position = position + COUNT_W'(1);
                    end else begin
                        last_dir = DIR_BWD;
                        position = position - COUNT_W'(1);
                    end
                end
                KIND_TICK: begin
                    speed        = period_count;
                    period_count = '0;
                    if (auto_mode) begin
                        err   = target_speed - speed;
                        sum   = int'(drive)
                              + int'(prop_gain) * int'(err >>> P_SHIFT)
                              - int'(diff_gain) * int'(prev_error >>> D_SHIFT);
                        sum16 = sum[15:0];
                        if (int'(sum16) > int'(DRIVE_MAX))
                            sum16 = DRIVE_MAX;
                        else if (sum16 < 0)
                            sum16 = '0;
                        prev_error    = err;
                        s.drive_valid = 1'b1;
                        s.drive_value = sum16[DRIVE_W-1:0];
                    end
                end
                KIND_CLEAR: begin
                    pulse_total = '0;
                    position    = '0;
                end
                default: ;
            endcase
            s.speed       = speed;
            s.direction   = (speed != 0) ? last_dir : DIR_STOP;
            s.pulse_total = pulse_total;
            s.position    = position;
            pending_status.push_back(s);
        endfunction

        function void check_field(string name, logic signed [63:0] expv,
                                  logic signed [63:0] actv);
            if (actv !== expv) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expv, actv);
            end
        endfunction

        function void check_status(t_status act);
            t_status e;
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: status word with none expected, speed %0d",
                         $time, act.speed);
                return;
            end
            e = pending_status.pop_front();
            check_field("speed",       64'(e.speed),       64'(act.speed));
            check_field("direction",   64'(e.direction),   64'(act.direction));
            check_field("pulse_total", 64'(e.pulse_total), 64'(act.pulse_total));
            check_field("position",    64'(e.position),    64'(act.position));
            check_field("drive_valid", 64'(e.drive_valid), 64'(act.drive_valid));
            check_field("drive_value", 64'(e.drive_value), 64'(act.drive_value));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_in_valid      = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_kind          = KIND_PULSE;
    logic                        i_dir_level     = LEVEL_BWD;
    logic [DRIVE_W-1:0]          i_current_drive = '0;
    logic                        o_out_valid;
    logic                        i_out_stall     = 1'b0;
    logic [SPEED_W-1:0]          o_speed;
    logic [1:0]                  o_direction;
    logic [COUNT_W-1:0]          o_pulse_total;
    logic signed [COUNT_W-1:0]   o_position;
    logic                        o_drive_valid;
    logic [DRIVE_W-1:0]          o_drive_value;
    logic                        i_cfg_valid     = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index     = CFG_TARGET_SPEED;
    logic [CFG_DATA_W-1:0]       i_cfg_data      = '0;

    encoder_speed_pd_regulator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_dir_level     (i_dir_level),
        .i_current_drive (i_current_drive),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_speed         (o_speed),
        .o_direction     (o_direction),
        .o_pulse_total   (o_pulse_total),
        .o_position      (o_position),
        .o_drive_valid   (o_drive_valid),
        .o_drive_value   (o_drive_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    regulator_model regulator = new();

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Status channel: stall pattern and checker
    // ------------------------------------------------------------------------
    // The stall pattern switches between free flow, light random stalls,
    // heavy random stalls and a fixed duty cycle, each held for a random stretch.
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_phase % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin : take_status
        t_status got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.speed       = o_speed;
            got.direction   = o_direction;
            got.pulse_total = o_pulse_total;
            got.position    = o_position;
            got.drive_valid = o_drive_valid;
            got.drive_value = o_drive_value;
            regulator.check_status(got);
        end
    end

    // ------------------------------------------------------------------------
    // Input and register drivers
    // ------------------------------------------------------------------------
    int burst_left = 0;

    // One input word. A gap may open before a new burst; valid stays high
    // within a burst, and the payload holds while stalled.
    task automatic send_word(input logic [1:0] kind, input logic dir_level,
                             input logic [DRIVE_W-1:0] drive);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind          <= kind;
        i_dir_level     <= dir_level;
        i_current_drive <= drive;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        regulator.take_word(kind, dir_level, drive);
    endtask

    // Stop sending and wait until every status word is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left  = 0;
        while (regulator.pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        regulator.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Gain and mode values go in with random junk in the unused data bits
    task automatic set_regulator(input logic [SPEED_W-1:0] target,
                                 input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] kd, input logic auto_on);
        write_reg(CFG_TARGET_SPEED, target);
        write_reg(CFG_PROP_GAIN, (16'($urandom) & 16'hFF00) | 16'(kp));
        write_reg(CFG_DIFF_GAIN, (16'($urandom) & 16'hFF00) | 16'(kd));
        write_reg(CFG_AUTO_MODE, (16'($urandom) & 16'hFFFE) | 16'(auto_on));
    endtask

    // Mostly runs of pulses in one direction broken up by ticks, with a few
    // clears, unused kinds and odd direction levels thrown in.
    task automatic run_random(input int count, input int tick_pct);
        logic               fwd;
        logic [1:0]         kind;
        logic [DRIVE_W-1:0] drive;
        int                 r;
        fwd = 1'($urandom_range(0, 1));
        repeat (count) begin
            if ($urandom_range(0, 15) == 0)
                fwd = ~fwd;
            r = $urandom_range(0, 99);
            if (r < 92 - tick_pct)
                kind = KIND_PULSE;
            else if (r < 92)
                kind = KIND_TICK;
            else if (r < 96)
                kind = KIND_CLEAR;
            else
                kind = KIND_UNUSED;
            drive = DRIVE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, 1024));
            send_word(kind, ($urandom_range(0, 19) == 0) ? ~fwd : fwd, drive);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SPEED_W-1:0] target;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: manual mode, no drive words
        send_word(KIND_PULSE, LEVEL_FWD, 11'd0);
        send_word(KIND_PULSE, LEVEL_FWD, 11'd0);
        send_word(KIND_PULSE, LEVEL_BWD, 11'd0);
        send_word(KIND_TICK, LEVEL_FWD, 11'd2047);   // manual tick, speed latched
        send_word(KIND_UNUSED, LEVEL_FWD, 11'd2047);
        send_word(KIND_CLEAR, LEVEL_BWD, 11'd0);     // speed and direction kept
        send_word(KIND_TICK, LEVEL_BWD, 11'd0);      // zero speed reads stopped
        send_word(KIND_PULSE, LEVEL_FWD, 11'd1024);
        drain();

        // Set point and gains at their top, auto mode
        set_regulator(16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        send_word(KIND_TICK, LEVEL_FWD, 11'd0);
        send_word(KIND_TICK, LEVEL_FWD, 11'd1024);
        send_word(KIND_TICK, LEVEL_FWD, 11'd2047);   // drive above the clamp
        repeat (4) send_word(KIND_PULSE, LEVEL_FWD, 11'd0);
        send_word(KIND_TICK, LEVEL_BWD, 11'd512);
        drain();

        // Set point at zero so the error turns negative
        set_regulator(16'd0, 8'd1, 8'd1, 1'b1);
        send_word(KIND_PULSE, LEVEL_BWD, 11'd0);
        send_word(KIND_TICK, LEVEL_BWD, 11'd1024);
        send_word(KIND_CLEAR, LEVEL_FWD, 11'd0);
        send_word(KIND_UNUSED, LEVEL_BWD, 11'd0);
        send_word(KIND_TICK, LEVEL_FWD, 11'd0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_regulator(16'hFFFF, 8'hFF, 8'hFF, 1'b1);
                1: set_regulator(16'd0, 8'd0, 8'd0, 1'b1);
                2: set_regulator(SPEED_W'($urandom_range(0, 40)),
                                 GAIN_W'($urandom_range(0, 255)),
                                 GAIN_W'($urandom_range(0, 255)), 1'b0);
                default: begin
                    target = SPEED_W'(($urandom_range(0, 3) == 0)
                                      ? $urandom_range(0, 65535)
                                      : $urandom_range(0, 40));
                    set_regulator(target, GAIN_W'($urandom_range(0, 255)),
                                  GAIN_W'($urandom_range(0, 255)),
                                  $urandom_range(0, 4) != 0);
                end
            endcase
            run_random(PHASE_WORDS, $urandom_range(5, 25));
            drain();
        end

        if (regulator.errors == 0 && regulator.pending_status.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/espd_pkg.sv
rtl/espd_pd_law.sv
rtl/encoder_speed_pd_regulator_top.sv
test/tb.sv
